// ===== rtl/core/tunnel_peer_link_fsm_defines.svh =====
// assertion macros for the tunnel peer link state machine checkers
`ifndef TUNNEL_PEER_LINK_FSM_DEFINES_SVH
`define TUNNEL_PEER_LINK_FSM_DEFINES_SVH

// same-cycle implication, disabled in reset
`define TPLF_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tplf assertion failed");

// next-cycle implication, disabled in reset
`define TPLF_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tplf assertion failed");

`endif

// ===== rtl/core/tplf_pkg.sv =====
// shared types and codes for the tunnel peer link state machine
`default_nettype none

package tplf_pkg;

   localparam int unsigned OP_W    = 3;
   localparam int unsigned LEN_W   = 16;
   localparam int unsigned PROTO_W = 16;
   localparam int unsigned FLAGS_W = 8;
   localparam int unsigned TICKS_W = 8;
   localparam int unsigned CSR_W   = 16;
   localparam int unsigned CSR_IDX_W = 1;

   localparam logic [LEN_W-1:0]   HEADER_BYTES  = 16'd4;
   localparam logic [LEN_W-1:0]   CONTROL_BYTES = 16'd1;
   localparam logic [PROTO_W-1:0] DATA_PROTO    = 16'h0800;

   localparam logic [PROTO_W-1:0] CONTROL_PROTOCOL_ID_RESET = 16'd35253;
   localparam logic [TICKS_W-1:0] RX_TIMEOUT_TICKS_RESET    = 8'd10;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CONTROL_PROTOCOL_ID = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RX_TIMEOUT_TICKS    = 1'd1;

   // operations
   localparam logic [OP_W-1:0] OP_CONNECT = 3'd0;
   localparam logic [OP_W-1:0] OP_LISTEN  = 3'd1;
   localparam logic [OP_W-1:0] OP_RX      = 3'd2;
   localparam logic [OP_W-1:0] OP_TX      = 3'd3;
   localparam logic [OP_W-1:0] OP_TICK    = 3'd4;

   // link states
   localparam logic [2:0] ST_INVALID    = 3'd0;
   localparam logic [2:0] ST_LISTENING  = 3'd1;
   localparam logic [2:0] ST_CONNECTING = 3'd2;
   localparam logic [2:0] ST_CONNECTED  = 3'd3;
   localparam logic [2:0] ST_CLOSED     = 3'd4;
   localparam logic [2:0] ST_GONE       = 3'd5;

   // control flag bits
   localparam int unsigned FLAG_SYN_BIT = 0;
   localparam int unsigned FLAG_ACK_BIT = 1;
   localparam int unsigned FLAG_RST_BIT = 2;

   // control packet to send
   localparam logic [1:0] SEND_NONE      = 2'd0;
   localparam logic [1:0] SEND_SYN       = 2'd1;
   localparam logic [1:0] SEND_ACK       = 2'd2;
   localparam logic [1:0] SEND_KEEPALIVE = 2'd3;

   // teardown kinds
   localparam logic [1:0] TDN_NONE    = 2'd0;
   localparam logic [1:0] TDN_DESTROY = 2'd1;
   localparam logic [1:0] TDN_ABORT   = 2'd2;

   // error codes
   localparam logic [2:0] ERR_OK            = 3'd0;
   localparam logic [2:0] ERR_PACKET_SHORT  = 3'd1;
   localparam logic [2:0] ERR_CONTROL_SHORT = 3'd2;
   localparam logic [2:0] ERR_NOT_CONNECTED = 3'd3;
   localparam logic [2:0] ERR_UNKNOWN_PROTO = 3'd4;
   localparam logic [2:0] ERR_BAD_STATE     = 3'd5;

   typedef struct packed {
      logic [OP_W-1:0]    operation;
      logic [LEN_W-1:0]   packet_length;
      logic [PROTO_W-1:0] protocol;
      logic [FLAGS_W-1:0] control_flags;
   } req_item_type;

   typedef struct packed {
      logic [1:0] send_control;
      logic       deliver_to_interface;
      logic       pass_to_transport;
      logic       bring_up_interface;
      logic [1:0] teardown;
      logic [2:0] link_state;
      logic [2:0] error_code;
   } rsp_item_type;

endpackage

`default_nettype wire

// ===== rtl/core/tplf_in_stage.sv =====
// input register stage holding one accepted item
`default_nettype none

module tplf_in_stage (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire tplf_pkg::req_item_type req_item,
   input  wire logic                  advance,
   output logic                       item_valid,
   output tplf_pkg::req_item_type     item
);

   logic                   valid_ff;
   logic                   valid_in;
   tplf_pkg::req_item_type item_ff;
   logic                   take;

   // full and not moving on: hold the item
   assign req_stall = valid_ff && !advance;
   assign take      = req_valid && !req_stall;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

`default_nettype wire

// ===== rtl/core/tplf_engine.sv =====
// link state registers and the per-item next-state and result logic
`default_nettype none

module tplf_engine (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         fire,
   input  wire tplf_pkg::req_item_type       item,
   input  wire logic [tplf_pkg::PROTO_W-1:0] control_protocol_id,
   input  wire logic [tplf_pkg::TICKS_W-1:0] rx_timeout_ticks,
   output tplf_pkg::rsp_item_type            result
);

   logic [2:0]                   state_ff, state_in;
   logic                         abort_ff, abort_in;
   logic                         armed_ff, armed_in;
   logic                         tx_seen_ff, tx_seen_in;
   logic                         rx_seen_ff, rx_seen_in;
   logic [tplf_pkg::TICKS_W-1:0] ticks_ff, ticks_in;
   logic [tplf_pkg::TICKS_W-1:0] ticks_dec;
   logic                         connect_now;
   logic                         syn, ack, rst;
   logic [1:0]                   tdn_kind;

   assign syn       = item.control_flags[tplf_pkg::FLAG_SYN_BIT];
   assign ack       = item.control_flags[tplf_pkg::FLAG_ACK_BIT];
   assign rst       = item.control_flags[tplf_pkg::FLAG_RST_BIT];
   assign ticks_dec = ticks_ff - 1'b1;
   assign tdn_kind  = abort_ff ? tplf_pkg::TDN_ABORT : tplf_pkg::TDN_DESTROY;

   always_comb begin
      state_in    = state_ff;
      abort_in    = abort_ff;
      armed_in    = armed_ff;
      tx_seen_in  = tx_seen_ff;
      rx_seen_in  = rx_seen_ff;
      ticks_in    = ticks_ff;
      connect_now = 1'b0;
      result      = '0;

      if (state_ff == tplf_pkg::ST_GONE || item.operation > tplf_pkg::OP_TICK) begin
         result.error_code = tplf_pkg::ERR_BAD_STATE;
      end else begin
         case (item.operation)
            tplf_pkg::OP_CONNECT: begin
               result.send_control = tplf_pkg::SEND_SYN;
               state_in = tplf_pkg::ST_CONNECTING;
               abort_in = 1'b1;
            end
            tplf_pkg::OP_LISTEN: begin
               state_in = tplf_pkg::ST_LISTENING;
            end
            tplf_pkg::OP_RX: begin
               if (item.packet_length < tplf_pkg::HEADER_BYTES) begin
                  result.error_code = tplf_pkg::ERR_PACKET_SHORT;
               end else begin
                  rx_seen_in = 1'b1;
                  if (item.protocol == tplf_pkg::DATA_PROTO) begin
                     if (state_ff == tplf_pkg::ST_CONNECTED) begin
                        result.deliver_to_interface = 1'b1;
                     end else begin
                        result.error_code = tplf_pkg::ERR_NOT_CONNECTED;
                     end
                  end else if (item.protocol == control_protocol_id) begin
                     // length minus header below the control size
                     if (item.packet_length - tplf_pkg::HEADER_BYTES
                         < tplf_pkg::CONTROL_BYTES) begin
                        result.error_code = tplf_pkg::ERR_CONTROL_SHORT;
                     end else begin
                        case (state_ff)
                           tplf_pkg::ST_LISTENING: begin
                              if (syn) begin
                                 result.send_control = tplf_pkg::SEND_ACK;
                                 connect_now = 1'b1;
                              end
                           end
                           tplf_pkg::ST_CONNECTING: begin
                              // rst wins over ack
                              if (rst) begin
                                 state_in = tplf_pkg::ST_CLOSED;
                              end else if (ack) begin
                                 connect_now = 1'b1;
                              end
                           end
                           tplf_pkg::ST_CONNECTED: begin
                              if (rst) begin
                                 state_in = tplf_pkg::ST_CLOSED;
                              end
                           end
                           default: begin
                              result.error_code = tplf_pkg::ERR_BAD_STATE;
                           end
                        endcase
                     end
                     if (connect_now) begin
                        armed_in = 1'b1;
                        state_in = tplf_pkg::ST_CONNECTED;
                        result.bring_up_interface = 1'b1;
                     end
                  end else begin
                     result.error_code = tplf_pkg::ERR_UNKNOWN_PROTO;
                  end
               end
            end
            tplf_pkg::OP_TX: begin
               result.pass_to_transport = 1'b1;
               tx_seen_in = 1'b1;
            end
            default: begin
               // timer tick
               if (armed_ff) begin
                  if (state_ff == tplf_pkg::ST_CLOSED) begin
                     result.teardown = tdn_kind;
                     state_in = tplf_pkg::ST_GONE;
                  end else begin
                     if (!tx_seen_ff) begin
                        result.send_control = tplf_pkg::SEND_KEEPALIVE;
                     end
                     if (!rx_seen_ff) begin
                        ticks_in = ticks_dec;
                        if (ticks_dec == '0) begin
                           result.teardown = tdn_kind;
                           state_in = tplf_pkg::ST_GONE;
                        end
                     end else begin
                        ticks_in = rx_timeout_ticks;
                     end
                     if (result.teardown == tplf_pkg::TDN_NONE) begin
                        tx_seen_in = 1'b0;
                        rx_seen_in = 1'b0;
                     end
                  end
               end
            end
         endcase
      end
      result.link_state = state_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= tplf_pkg::ST_INVALID;
         abort_ff   <= 1'b0;
         armed_ff   <= 1'b0;
         tx_seen_ff <= 1'b0;
         rx_seen_ff <= 1'b0;
         ticks_ff   <= tplf_pkg::RX_TIMEOUT_TICKS_RESET;
      end else if (fire) begin
         state_ff   <= state_in;
         abort_ff   <= abort_in;
         armed_ff   <= armed_in;
         tx_seen_ff <= tx_seen_in;
         rx_seen_ff <= rx_seen_in;
         ticks_ff   <= ticks_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/tplf_out_stage.sv =====
// result register driving the response channel
`default_nettype none

module tplf_out_stage (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   item_valid,
   input  wire tplf_pkg::rsp_item_type result,
   input  wire logic                   rsp_stall,
   output logic                        load,
   output logic                        rsp_valid,
   output tplf_pkg::rsp_item_type      rsp_item
);

   logic                   valid_ff;
   logic                   valid_in;
   tplf_pkg::rsp_item_type item_ff;

   // room when empty or the held item leaves this cycle
   assign load = item_valid && (!valid_ff || !rsp_stall);

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= result;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_item  = item_ff;

endmodule

`default_nettype wire

// ===== rtl/core/tunnel_peer_link_fsm.sv =====
// the input register holds an accepted item; the result register drives rsp
// throughput: one item per cycle unless rsp stalls; state update sets the pace
// an empty input register takes an item while a finished result waits to be taken
// reset (synchronous): link state invalid, flags cleared, idle countdown and
// registers back to their default values, both stages empty
`default_nettype none

module tunnel_peer_link_fsm (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_write_enable,
   input  wire logic [tplf_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [tplf_pkg::CSR_W-1:0]          csr_write_data,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [tplf_pkg::OP_W-1:0]           req_operation,
   input  wire logic [tplf_pkg::LEN_W-1:0]          req_packet_length,
   input  wire logic [tplf_pkg::PROTO_W-1:0]        req_protocol,
   input  wire logic [tplf_pkg::FLAGS_W-1:0]        req_control_flags,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [1:0]                               rsp_send_control,
   output logic                                     rsp_deliver_to_interface,
   output logic                                     rsp_pass_to_transport,
   output logic                                     rsp_bring_up_interface,
   output logic [1:0]                               rsp_teardown,
   output logic [2:0]                               rsp_link_state,
   output logic [2:0]                               rsp_error_code
);

   logic [tplf_pkg::PROTO_W-1:0] ctrl_proto_ff;
   logic [tplf_pkg::TICKS_W-1:0] rx_timeout_ff;
   tplf_pkg::req_item_type       req_item;
   tplf_pkg::req_item_type       item;
   tplf_pkg::rsp_item_type       result;
   tplf_pkg::rsp_item_type       rsp_item;
   logic                         item_valid;
   logic                         load;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_proto_ff <= tplf_pkg::CONTROL_PROTOCOL_ID_RESET;
         rx_timeout_ff <= tplf_pkg::RX_TIMEOUT_TICKS_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            tplf_pkg::CSR_CONTROL_PROTOCOL_ID: ctrl_proto_ff <= csr_write_data;
            tplf_pkg::CSR_RX_TIMEOUT_TICKS:
               rx_timeout_ff <= csr_write_data[tplf_pkg::TICKS_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign req_item.operation     = req_operation;
   assign req_item.packet_length = req_packet_length;
   assign req_item.protocol      = req_protocol;
   assign req_item.control_flags = req_control_flags;

   tplf_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_item   (req_item),
      .advance    (load),
      .item_valid (item_valid),
      .item       (item)
   );

   tplf_engine u_engine (
      .clock               (clock),
      .reset               (reset),
      .fire                (load),
      .item                (item),
      .control_protocol_id (ctrl_proto_ff),
      .rx_timeout_ticks    (rx_timeout_ff),
      .result              (result)
   );

   tplf_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .result     (result),
      .rsp_stall  (rsp_stall),
      .load       (load),
      .rsp_valid  (rsp_valid),
      .rsp_item   (rsp_item)
   );

   assign rsp_send_control         = rsp_item.send_control;
   assign rsp_deliver_to_interface = rsp_item.deliver_to_interface;
   assign rsp_pass_to_transport    = rsp_item.pass_to_transport;
   assign rsp_bring_up_interface   = rsp_item.bring_up_interface;
   assign rsp_teardown             = rsp_item.teardown;
   assign rsp_link_state           = rsp_item.link_state;
   assign rsp_error_code           = rsp_item.error_code;

endmodule

`default_nettype wire

// ===== rtl/core/tplf_checker.sv =====
// port-level checks for the tunnel peer link state machine, bound to the top level
`default_nettype none

`include "tunnel_peer_link_fsm_defines.svh"

module tplf_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [1:0] rsp_send_control,
   input wire logic       rsp_deliver_to_interface,
   input wire logic       rsp_bring_up_interface,
   input wire logic [1:0] rsp_teardown,
   input wire logic [2:0] rsp_link_state,
   input wire logic [2:0] rsp_error_code
);

   // a stalled item stays put
   `TPLF_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_send_control) && $stable(rsp_teardown)
      && $stable(rsp_link_state) && $stable(rsp_error_code))

   // any teardown leaves the link gone
   `TPLF_ASSERT_NOW(a_teardown_gone, rsp_valid && rsp_teardown != tplf_pkg::TDN_NONE,
      rsp_link_state == tplf_pkg::ST_GONE)

   // delivery only while connected and clean
   `TPLF_ASSERT_NOW(a_deliver_conn, rsp_valid && rsp_deliver_to_interface,
      rsp_link_state == tplf_pkg::ST_CONNECTED && rsp_error_code == tplf_pkg::ERR_OK)

   // bring-up goes with entering connected
   `TPLF_ASSERT_NOW(a_up_conn, rsp_valid && rsp_bring_up_interface,
      rsp_link_state == tplf_pkg::ST_CONNECTED)

   // once gone, items other than the teardown itself report bad state
   `TPLF_ASSERT_NOW(a_gone_err,
      rsp_valid && rsp_link_state == tplf_pkg::ST_GONE && rsp_teardown == tplf_pkg::TDN_NONE,
      rsp_error_code == tplf_pkg::ERR_BAD_STATE)

endmodule

bind tunnel_peer_link_fsm tplf_checker u_tplf_checker (
   .clock                    (clock),
   .reset                    (reset),
   .rsp_valid                (rsp_valid),
   .rsp_stall                (rsp_stall),
   .rsp_send_control         (rsp_send_control),
   .rsp_deliver_to_interface (rsp_deliver_to_interface),
   .rsp_bring_up_interface   (rsp_bring_up_interface),
   .rsp_teardown             (rsp_teardown),
   .rsp_link_state           (rsp_link_state),
   .rsp_error_code           (rsp_error_code)
);

`default_nettype wire

// ===== tb/sv/tplf_tb_pkg.sv =====
// link state predictor and result scoreboard for the tunnel peer link testbench
package tplf_tb_pkg;

   import tplf_pkg::*;

   // predicted state of the peer link plus its two registers
   typedef struct {
      logic [2:0]         state;
      bit                 abort_armed;
      bit                 tick_armed;
      bit                 tx_seen;
      bit                 rx_seen;
      logic [TICKS_W-1:0] ticks_left;
      logic [PROTO_W-1:0] control_id;
      logic [TICKS_W-1:0] timeout_reload;
   } link_model_type;

   function automatic rsp_item_type peer_link_next(inout link_model_type s,
                                                   input req_item_type r);
      rsp_item_type o;
      bit connect_now;
      o = '0;
      connect_now = 1'b0;
      if (s.state == ST_GONE || r.operation > OP_TICK) begin
         o.error_code = ERR_BAD_STATE;
      end else begin
         case (r.operation)
            OP_CONNECT: begin
               o.send_control = SEND_SYN;
               s.state = ST_CONNECTING;
               s.abort_armed = 1'b1;
            end
            OP_LISTEN: s.state = ST_LISTENING;
            OP_RX: begin
               if (r.packet_length < HEADER_BYTES) begin
                  o.error_code = ERR_PACKET_SHORT;
               end else begin
                  // data protocol is checked first, so a control id of 0x0800 means data
                  if (r.protocol == DATA_PROTO) begin
                     if (s.state == ST_CONNECTED) o.deliver_to_interface = 1'b1;
                     else o.error_code = ERR_NOT_CONNECTED;
                  end else if (r.protocol == s.control_id) begin
                     if (r.packet_length - HEADER_BYTES < CONTROL_BYTES) begin
                        o.error_code = ERR_CONTROL_SHORT;
                     end else begin
                        case (s.state)
                           ST_LISTENING: begin
                              if (r.control_flags[FLAG_SYN_BIT]) begin
                                 o.send_control = SEND_ACK;
                                 connect_now = 1'b1;
                              end
                           end
                           ST_CONNECTING: begin
                              if (r.control_flags[FLAG_RST_BIT]) s.state = ST_CLOSED;
                              else if (r.control_flags[FLAG_ACK_BIT]) connect_now = 1'b1;
                           end
                           ST_CONNECTED: begin
                              if (r.control_flags[FLAG_RST_BIT]) s.state = ST_CLOSED;
                           end
                           default: o.error_code = ERR_BAD_STATE;
                        endcase
                     end
                     if (connect_now) begin
                        s.tick_armed = 1'b1;
                        s.state = ST_CONNECTED;
                        o.bring_up_interface = 1'b1;
                     end
                  end else begin
                     o.error_code = ERR_UNKNOWN_PROTO;
                  end
                  s.rx_seen = 1'b1;
               end
            end
            OP_TX: begin
               o.pass_to_transport = 1'b1;
               s.tx_seen = 1'b1;
            end
            default: begin
               if (s.tick_armed) begin
                  if (s.state == ST_CLOSED) begin
                     o.teardown = s.abort_armed ? TDN_ABORT : TDN_DESTROY;
                     s.state = ST_GONE;
                  end else begin
                     if (!s.tx_seen) o.send_control = SEND_KEEPALIVE;
                     if (!s.rx_seen) begin
                        s.ticks_left = s.ticks_left - 1'b1;
                        if (s.ticks_left == '0) begin
                           o.teardown = s.abort_armed ? TDN_ABORT : TDN_DESTROY;
                           s.state = ST_GONE;
                        end
                     end else begin
                        s.ticks_left = s.timeout_reload;
                     end
                     if (o.teardown == TDN_NONE) begin
                        s.tx_seen = 1'b0;
                        s.rx_seen = 1'b0;
                     end
                  end
               end
            end
         endcase
      end
      o.link_state = s.state;
      return o;
   endfunction

   class link_scoreboard;
      link_model_type model;
      rsp_item_type   due_results[$];
      int             failures;

      function new();
         model.state          = ST_INVALID;
         model.abort_armed    = 1'b0;
         model.tick_armed     = 1'b0;
         model.tx_seen        = 1'b0;
         model.rx_seen        = 1'b0;
         model.ticks_left     = RX_TIMEOUT_TICKS_RESET;
         model.control_id     = CONTROL_PROTOCOL_ID_RESET;
         model.timeout_reload = RX_TIMEOUT_TICKS_RESET;
         failures = 0;
      endfunction

      function void note_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] data);
         if (idx == CSR_CONTROL_PROTOCOL_ID) model.control_id = data;
         else if (idx == CSR_RX_TIMEOUT_TICKS) model.timeout_reload = data[TICKS_W-1:0];
      endfunction

      function void note_item(req_item_type r);
         due_results.push_back(peer_link_next(model, r));
      endfunction

      function void check_field(string name, logic [2:0] want, logic [2:0] got);
         if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
         end
      endfunction

      function void check_result(rsp_item_type got);
         rsp_item_type want;
         if (due_results.size() == 0) begin
            $error("result item with no outstanding request");
            failures++;
            return;
         end
         want = due_results.pop_front();
         check_field("send_control", want.send_control, got.send_control);
         check_field("deliver_to_interface", want.deliver_to_interface, got.deliver_to_interface);
         check_field("pass_to_transport", want.pass_to_transport, got.pass_to_transport);
         check_field("bring_up_interface", want.bring_up_interface, got.bring_up_interface);
         check_field("teardown", want.teardown, got.teardown);
         check_field("link_state", want.link_state, got.link_state);
         check_field("error_code", want.error_code, got.error_code);
      endfunction
   endclass

endpackage

// ===== tb/sv/tb.sv =====
// testbench top for the tunnel peer link state machine
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tplf_pkg::*;
   import tplf_tb_pkg::*;

   localparam int STUCK_LIMIT = 2000;
   localparam int PHASE_ITEMS = 125;
   localparam logic [FLAGS_W-1:0] F_SYN = FLAGS_W'(1 << FLAG_SYN_BIT);
   localparam logic [FLAGS_W-1:0] F_ACK = FLAGS_W'(1 << FLAG_ACK_BIT);
   localparam logic [FLAGS_W-1:0] F_RST = FLAGS_W'(1 << FLAG_RST_BIT);

   logic                 clock;
   logic                 reset;
   logic                 csr_write_enable;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_write_data;
   logic                 req_valid;
   logic                 req_stall;
   logic [OP_W-1:0]      req_operation;
   logic [LEN_W-1:0]     req_packet_length;
   logic [PROTO_W-1:0]   req_protocol;
   logic [FLAGS_W-1:0]   req_control_flags;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [1:0]           rsp_send_control;
   logic                 rsp_deliver_to_interface;
   logic                 rsp_pass_to_transport;
   logic                 rsp_bring_up_interface;
   logic [1:0]           rsp_teardown;
   logic [2:0]           rsp_link_state;
   logic [2:0]           rsp_error_code;

   rsp_item_type   rsp_seen;
   link_scoreboard sb;
   req_item_type   req_cur;
   req_item_type   directed_q[$];
   bit             req_busy = 1'b0;
   bit             allow_teardown = 1'b0;
   int             sender_idle_pct = 0;
   int             rsp_stall_pct = 0;
   int             hold_off_request = 0;
   int             stuck_cycles = 0;

   tunnel_peer_link_fsm dut (
      .clock                    (clock),
      .reset                    (reset),
      .csr_write_enable         (csr_write_enable),
      .csr_index                (csr_index),
      .csr_write_data           (csr_write_data),
      .req_valid                (req_valid),
      .req_stall                (req_stall),
      .req_operation            (req_operation),
      .req_packet_length        (req_packet_length),
      .req_protocol             (req_protocol),
      .req_control_flags        (req_control_flags),
      .rsp_valid                (rsp_valid),
      .rsp_stall                (rsp_stall),
      .rsp_send_control         (rsp_send_control),
      .rsp_deliver_to_interface (rsp_deliver_to_interface),
      .rsp_pass_to_transport    (rsp_pass_to_transport),
      .rsp_bring_up_interface   (rsp_bring_up_interface),
      .rsp_teardown             (rsp_teardown),
      .rsp_link_state           (rsp_link_state),
      .rsp_error_code           (rsp_error_code)
   );

   assign rsp_seen = {rsp_send_control, rsp_deliver_to_interface, rsp_pass_to_transport,
                      rsp_bring_up_interface, rsp_teardown, rsp_link_state, rsp_error_code};

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // result checking and the no-progress watchdog
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_seen);
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) stuck_cycles = 0;
      else stuck_cycles++;
      if (stuck_cycles >= STUCK_LIMIT) begin
         $display("FAIL tunnel_peer_link_fsm");
         $finish;
      end
   end

   // receiver: random stall, plus a long hold-off on request
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_request > 0) begin
            hold_left = hold_off_request;
            hold_off_request = 0;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
         end
      end
   end

   function automatic req_item_type make_item(logic [OP_W-1:0] op, logic [LEN_W-1:0] len,
                                              logic [PROTO_W-1:0] proto,
                                              logic [FLAGS_W-1:0] flags);
      req_item_type r;
      r.operation     = op;
      r.packet_length = len;
      r.protocol      = proto;
      r.control_flags = flags;
      return r;
   endfunction

   // random item biased toward well-formed handshakes; teardown is held back
   // until the final phase since only a reset leaves the gone state
   function automatic req_item_type next_request();
      req_item_type   r;
      link_model_type trial;
      rsp_item_type   o;
      int             pick;
      for (int k = 0; k < 8; k++) begin
         pick = $urandom_range(99);
         if (pick < 4) r.operation = OP_W'($urandom_range(7, 5));
         else if (pick < 12) r.operation = OP_CONNECT;
         else if (pick < 20) r.operation = OP_LISTEN;
         else if (pick < 62) r.operation = OP_RX;
         else if (pick < 77) r.operation = OP_TX;
         else r.operation = OP_TICK;
         case ($urandom_range(9))
            0: r.packet_length = LEN_W'($urandom_range(3));
            1: r.packet_length = HEADER_BYTES;
            2: r.packet_length = LEN_W'($urandom);
            default: r.packet_length = LEN_W'($urandom_range(1500, 5));
         endcase
         pick = $urandom_range(9);
         if (pick < 4) r.protocol = DATA_PROTO;
         else if (pick < 8) r.protocol = sb.model.control_id;
         else r.protocol = PROTO_W'($urandom);
         case ($urandom_range(7))
            0: r.control_flags = F_SYN;
            1: r.control_flags = F_ACK;
            2: r.control_flags = F_RST;
            3: r.control_flags = F_RST | F_ACK;
            default: r.control_flags = FLAGS_W'($urandom);
         endcase
         trial = sb.model;
         o = peer_link_next(trial, r);
         if (allow_teardown || o.teardown == TDN_NONE) return r;
      end
      return make_item(OP_LISTEN, '0, '0, '0);
   endfunction

   task automatic drive_items(input int count);
      int issued;
      int taken;
      req_item_type it;
      issued = 0;
      taken = 0;
      while (taken < count) begin
         @(posedge clock);
         if (req_busy && !req_stall) begin
            sb.note_item(req_cur);
            req_busy = 1'b0;
            taken++;
         end
         if (!req_busy && issued < count && $urandom_range(99) >= sender_idle_pct) begin
            if (directed_q.size() != 0) it = directed_q.pop_front();
            else it = next_request();
            req_cur = it;
            req_valid         <= 1'b1;
            req_operation     <= it.operation;
            req_packet_length <= it.packet_length;
            req_protocol      <= it.protocol;
            req_control_flags <= it.control_flags;
            req_busy = 1'b1;
            issued++;
         end else if (!req_busy) begin
            req_valid <= 1'b0;
         end
      end
   endtask

   task automatic run_directed();
      drive_items(directed_q.size());
   endtask

   task automatic wait_drained();
      while (sb.due_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      sb.note_register(idx, data);
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      int idle_tab[4];
      int stall_tab[4];
      logic [CSR_W-1:0] ctrl_tab[8];
      logic [TICKS_W-1:0] timeout_tab[8];
      logic [PROTO_W-1:0] cid;

      sb = new();
      reset             <= 1'b1;
      csr_write_enable  <= 1'b0;
      csr_index         <= '0;
      csr_write_data    <= '0;
      req_valid         <= 1'b0;
      req_operation     <= '0;
      req_packet_length <= '0;
      req_protocol      <= '0;
      req_control_flags <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed walk through every state but gone, with register defaults
      cid = CONTROL_PROTOCOL_ID_RESET;
      directed_q.push_back(make_item(OP_TICK, '0, '0, '0));           // unarmed tick
      directed_q.push_back(make_item(OP_RX, 16'd5, cid, F_SYN));      // control while invalid
      directed_q.push_back(make_item(OP_RX, HEADER_BYTES, DATA_PROTO, '0));
      directed_q.push_back(make_item(OP_RX, 16'd0, DATA_PROTO, '0));  // short packets
      directed_q.push_back(make_item(OP_RX, 16'd3, cid, F_SYN));
      directed_q.push_back(make_item(OP_RX, 16'hFFFF, 16'h0000, 8'hFF));
      directed_q.push_back(make_item(OP_RX, HEADER_BYTES, 16'hFFFF, '0));
      directed_q.push_back(make_item(3'd5, 16'hFFFF, 16'hFFFF, 8'hFF)); // unused codes
      directed_q.push_back(make_item(3'd6, '0, '0, '0));
      directed_q.push_back(make_item(3'd7, '0, '0, '0));
      directed_q.push_back(make_item(OP_TX, '0, '0, '0));
      directed_q.push_back(make_item(OP_LISTEN, '0, '0, '0));
      directed_q.push_back(make_item(OP_RX, HEADER_BYTES, cid, F_SYN)); // control short
      directed_q.push_back(make_item(OP_RX, 16'd5, cid, 8'h00));
      directed_q.push_back(make_item(OP_RX, 16'd5, cid, 8'hFF));        // syn answers ack
      directed_q.push_back(make_item(OP_RX, 16'hFFFF, DATA_PROTO, 8'hFF));
      directed_q.push_back(make_item(OP_TICK, '0, '0, '0));             // reload tick
      directed_q.push_back(make_item(OP_TICK, '0, '0, '0));             // keepalive tick
      directed_q.push_back(make_item(OP_RX, 16'd5, cid, F_ACK));
      directed_q.push_back(make_item(OP_RX, 16'd5, cid, F_RST));        // connected to closed
      directed_q.push_back(make_item(OP_RX, 16'd5, cid, F_SYN));        // control while closed
      directed_q.push_back(make_item(OP_CONNECT, '0, '0, '0));
      directed_q.push_back(make_item(OP_RX, 16'd5, cid, F_RST | F_ACK)); // rst wins over ack
      directed_q.push_back(make_item(OP_CONNECT, '0, '0, '0));
      directed_q.push_back(make_item(OP_RX, 16'd5, cid, F_SYN));
      directed_q.push_back(make_item(OP_RX, 16'd5, cid, F_ACK));
      directed_q.push_back(make_item(OP_TX, '0, '0, '0));
      run_directed();
      wait_drained();

      idle_tab  = '{0, 70, 0, 27};
      stall_tab = '{0, 0, 70, 27};
      ctrl_tab    = '{16'h0000, 16'hFFFF, DATA_PROTO, CSR_W'($urandom),
                      CONTROL_PROTOCOL_ID_RESET, CSR_W'($urandom), 16'h5555, 16'hAAAA};
      timeout_tab = '{8'd1, 8'd255, 8'd0, TICKS_W'($urandom_range(255, 1)),
                      8'd2, 8'd0, 8'd255, 8'd1};
      for (int p = 0; p < 8; p++) begin
         csr_write(CSR_CONTROL_PROTOCOL_ID, ctrl_tab[p]);
         // upper byte of the timeout write is dont-care
         csr_write(CSR_RX_TIMEOUT_TICKS, {8'($urandom), timeout_tab[p]});
         sender_idle_pct = idle_tab[p % 4];
         rsp_stall_pct   = stall_tab[p % 4];
         if (p == 2) hold_off_request = 300;
         drive_items(PHASE_ITEMS);
         wait_drained();
      end

      // final phase: back to defaults, connect, then tear down by one of two paths
      sender_idle_pct = 27;
      rsp_stall_pct   = 27;
      csr_write(CSR_CONTROL_PROTOCOL_ID, CONTROL_PROTOCOL_ID_RESET);
      csr_write(CSR_RX_TIMEOUT_TICKS, CSR_W'(RX_TIMEOUT_TICKS_RESET));
      cid = CONTROL_PROTOCOL_ID_RESET;
      directed_q.push_back(make_item(OP_CONNECT, '0, '0, '0));
      directed_q.push_back(make_item(OP_RX, 16'd5, cid, F_ACK));
      if ($urandom_range(1)) begin
         directed_q.push_back(make_item(OP_RX, 16'd5, cid, F_RST));
         directed_q.push_back(make_item(OP_TICK, '0, '0, '0));          // closed tick
      end else begin
         directed_q.push_back(make_item(OP_RX, 16'd64, DATA_PROTO, '0));
         directed_q.push_back(make_item(OP_TICK, '0, '0, '0));          // reload
         // idle countdown runs out on the last tick, with its keepalive
         repeat (RX_TIMEOUT_TICKS_RESET) directed_q.push_back(make_item(OP_TICK, '0, '0, '0));
      end
      run_directed();
      allow_teardown = 1'b1;
      drive_items(20);
      wait_drained();

      if (sb.failures == 0) begin
         $display("PASS tunnel_peer_link_fsm");
      end else begin
         $display("FAIL tunnel_peer_link_fsm");
      end
      $finish;
   end

endmodule
